// ===== hdl/swizzled_pixel_memory_access_macros.svh =====
// Assertion macros for the swizzled pixel memory access block.
// Used by the top level; relies on the signals clk and rst_n in scope.
`ifndef SWIZZLED_PIXEL_MEMORY_ACCESS_MACROS_SVH
`define SWIZZLED_PIXEL_MEMORY_ACCESS_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset
`define SPMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spma assertion failed");
// Next-cycle implication, disabled in reset
`define SPMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spma assertion failed");
`else
`define SPMA_ASSERT_IMP(lbl, ante, cons)
`define SPMA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/spma_pkg.sv =====
// Shared types and constants of the swizzled pixel memory access block.
// No dependencies; imported by every module of the block but spma_ram.
`default_nettype none
package spma_pkg;

  // Memory geometry
  localparam int VRAM_BYTES = 4194304;
  localparam int AW         = $clog2(VRAM_BYTES);
  localparam int WAW        = AW - 2;
  localparam int VRAM_WORDS = VRAM_BYTES / 4;

  // Port widths
  localparam int IN_W   = 104;
  localparam int OUT_W  = 40;
  localparam int CFG_AW = 5;

  // Depth buffer block flip, as a word address mask
  localparam logic [WAW-1:0] Z_XOR = WAW'('h600);

  // Colour masks
  localparam logic [31:0] RGB24_MASK = 32'h00FF_FFFF;
  localparam logic [15:0] C16_ATOP   = 16'h8000;
  localparam logic [15:0] C16_RMASK  = 16'h7C00;
  localparam logic [15:0] C16_GMASK  = 16'h03E0;

  // Operation codes
  typedef enum logic [2:0] {
    OP_PIX_WR   = 3'd0,
    OP_PIX_RD   = 3'd1,
    OP_LIN32_WR = 3'd2,
    OP_LIN16_WR = 3'd3,
    OP_LIN32_RD = 3'd4,
    OP_LIN16_RD = 3'd5,
    OP_PAL      = 3'd6
  } op_t;

  // Pixel storage format codes
  localparam logic [5:0] PSM_C32  = 6'd0;
  localparam logic [5:0] PSM_C24  = 6'd1;
  localparam logic [5:0] PSM_C16  = 6'd2;
  localparam logic [5:0] PSM_C16S = 6'd10;
  localparam logic [5:0] PSM_T8   = 6'd19;
  localparam logic [5:0] PSM_T4   = 6'd20;
  localparam logic [5:0] PSM_T8H  = 6'd27;
  localparam logic [5:0] PSM_T4HL = 6'd36;
  localparam logic [5:0] PSM_T4HH = 6'd44;
  localparam logic [5:0] PSM_Z32  = 6'd48;
  localparam logic [5:0] PSM_Z24  = 6'd49;
  localparam logic [5:0] PSM_Z16  = 6'd50;
  localparam logic [5:0] PSM_Z16S = 6'd58;

  // Palette colour formats
  localparam logic [3:0] CF_32  = 4'd0;
  localparam logic [3:0] CF_24  = 4'd1;
  localparam logic [3:0] CF_16  = 4'd2;
  localparam logic [3:0] CF_16S = 4'd10;

  // Register indexes
  localparam logic [2:0] REG_ALPHA0     = 3'd0;
  localparam logic [2:0] REG_ALPHA1     = 3'd1;
  localparam logic [2:0] REG_ABZ        = 3'd2;
  localparam logic [2:0] REG_CLUT_BASE  = 3'd3;
  localparam logic [2:0] REG_CLUT_FMT   = 3'd4;
  localparam logic [2:0] REG_CLUT_LAY2  = 3'd5;
  localparam logic [2:0] REG_CLUT_WIDTH = 3'd6;
  localparam logic [2:0] REG_CLUT_ORG   = 3'd7;

  typedef enum logic [2:0] {SW_32, SW_16, SW_16S, SW_8, SW_4} swz_t;
  typedef enum logic [2:0] {K_NONE, K_W32, K_W24, K_H16, K_B8, K_N4} kind_t;
  typedef enum logic [1:0] {XP_NONE, XP_24, XP_16} xp_t;
  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_ADDR, ST_DATA} state_t;

  typedef struct packed {
    logic [7:0]  alpha0;
    logic [7:0]  alpha1;
    logic        abz;
    logic [13:0] clut_base;
    logic [3:0]  clut_format;
    logic        clut_layout_two;
    logic [5:0]  clut_width;
    logic [15:0] clut_origin;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  psm;
    logic [10:0] x;
    logic [10:0] y;
    logic [13:0] bp;
    logic [5:0]  bw;
    logic [31:0] value;
    logic [20:0] lin;
  } req_t;

  typedef struct packed {
    logic [WAW-1:0] waddr;
    logic [1:0]     lane;
    logic           nib;
    kind_t          kind;
    logic           wr;
    logic           ok;
    xp_t            xp;
    logic           zero;
  } acc_t;

endpackage
`default_nettype wire

// ===== hdl/swizzled_pixel_memory_access.sv =====
// Swizzled pixel memory access: 4 MB video memory, one item in flight.
// After reset the memory is cleared one word a cycle, all 1,048,576 words;
// no item is accepted then, configuration writes are taken as usual. Each
// item then passes an accept state, an address and memory read state, and a
// data state that forms the result and writes the merged word back. No new
// item is taken before the last one leaves the data state, as the single word
// memory is read, modified and written back; a stalled result holds the data
// state. Depends on spma_pkg, spma_regs, spma_agen, spma_dpath and spma_ram.
`default_nettype none
`include "swizzled_pixel_memory_access_macros.svh"
module swizzled_pixel_memory_access (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // operation[2:0] psm[8:3] x[19:9] y[30:20] bp[44:31] bw[50:45]
  // value[82:51] linear_index[103:83]
  input  wire logic [spma_pkg::IN_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // read_data[31:0] supported[32], zero fill above
  output logic      [spma_pkg::OUT_W-1:0]  out_tdata,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [spma_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic      [31:0]                 cfg_prdata,
  output logic                             cfg_pready
);
  import spma_pkg::*;

  state_t         state_r, state_nxt;
  logic [WAW-1:0] clr_r, clr_nxt;
  req_t           req_r, req_nxt;
  acc_t           acc, acc_r, acc_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  cfg_t           cfg;
  logic           ram_we;
  logic [WAW-1:0] ram_waddr;
  logic [31:0]    ram_wdata, ram_rdata;
  logic           out_load;
  logic [31:0]    dp_rd, dp_wdata;

  assign cfg_pready = 1'b1;

  spma_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  spma_agen u_agen (
    .req (req_r),
    .cfg (cfg),
    .acc (acc)
  );

  spma_dpath u_dpath (
    .acc     (acc_r),
    .cfg     (cfg),
    .rdata   (ram_rdata),
    .value   (req_r.value),
    .rd_data (dp_rd),
    .wdata   (dp_wdata)
  );

  spma_ram #(
    .DEPTH (VRAM_WORDS),
    .WIDTH (32)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (acc.waddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == WAW'(VRAM_WORDS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_DATA;
      ST_DATA:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = acc_r.waddr;
    ram_wdata = dp_wdata;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 32'd0;
      end
      ST_IDLE: in_tready = 1'b1;
      ST_DATA: begin
        out_load = !out_valid_r || out_tready;
        ram_we   = out_load && acc_r.wr && (acc_r.kind != K_NONE);
      end
      default: in_tready = 1'b0;
    endcase
  end

  // Datapath register updates
  always_comb begin
    clr_nxt = (state_r == ST_CLEAR) ? clr_r + 1'b1 : clr_r;
    req_nxt = req_r;
    if (in_tvalid && in_tready) begin
      req_nxt.op    = op_t'(in_tdata[2:0]);
      req_nxt.psm   = in_tdata[8:3];
      req_nxt.x     = in_tdata[19:9];
      req_nxt.y     = in_tdata[30:20];
      req_nxt.bp    = in_tdata[44:31];
      req_nxt.bw    = in_tdata[50:45];
      req_nxt.value = in_tdata[82:51];
      req_nxt.lin   = in_tdata[103:83];
    end
    acc_nxt = (state_r == ST_ADDR) ? acc : acc_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    out_data_nxt = out_load ? {7'd0, acc_r.ok, dp_rd} : out_data_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SPMA_ASSERT_NXT(a_accept_to_addr, in_tvalid && in_tready, state_r == ST_ADDR)
  `SPMA_ASSERT_NXT(a_addr_to_data, state_r == ST_ADDR, state_r == ST_DATA)
  `SPMA_ASSERT_IMP(a_no_bad_write, ram_we && state_r == ST_DATA, acc_r.ok)
  `SPMA_ASSERT_IMP(a_result_from_data, $rose(out_valid_r), $past(state_r) == ST_DATA)
  `SPMA_ASSERT_IMP(a_clear_blocks_input, state_r == ST_CLEAR, !in_tready && ram_wdata == 32'd0)
endmodule
`default_nettype wire

// ===== hdl/spma_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none
module spma_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== hdl/spma_regs.sv =====
// Configuration register file with an APB-style write/read port.
// Depends on spma_pkg (cfg_t, register indexes).
`default_nettype none
module spma_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spma_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output spma_pkg::cfg_t                   cfg
);
  import spma_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr  = psel & penable & pwrite;

  // Update the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_ALPHA0:     cfg_nxt.alpha0          = pwdata[7:0];
        REG_ALPHA1:     cfg_nxt.alpha1          = pwdata[7:0];
        REG_ABZ:        cfg_nxt.abz             = pwdata[0];
        REG_CLUT_BASE:  cfg_nxt.clut_base       = pwdata[13:0];
        REG_CLUT_FMT:   cfg_nxt.clut_format     = pwdata[3:0];
        REG_CLUT_LAY2:  cfg_nxt.clut_layout_two = pwdata[0];
        REG_CLUT_WIDTH: cfg_nxt.clut_width      = pwdata[5:0];
        REG_CLUT_ORG:   cfg_nxt.clut_origin     = pwdata[15:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_ALPHA0:     prdata = {24'd0, cfg_r.alpha0};
      REG_ALPHA1:     prdata = {24'd0, cfg_r.alpha1};
      REG_ABZ:        prdata = {31'd0, cfg_r.abz};
      REG_CLUT_BASE:  prdata = {18'd0, cfg_r.clut_base};
      REG_CLUT_FMT:   prdata = {28'd0, cfg_r.clut_format};
      REG_CLUT_LAY2:  prdata = {31'd0, cfg_r.clut_layout_two};
      REG_CLUT_WIDTH: prdata = {26'd0, cfg_r.clut_width};
      REG_CLUT_ORG:   prdata = {16'd0, cfg_r.clut_origin};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule
`default_nettype wire

// ===== hdl/spma_agen.sv =====
// Address generator: decodes an access and maps it through the page, block
// and column swizzles to a word address and lane. Depends on spma_pkg.
`default_nettype none
module spma_agen (
  input  spma_pkg::req_t req,
  input  spma_pkg::cfg_t cfg,
  output spma_pkg::acc_t acc
);
  import spma_pkg::*;

  // Block, column and palette swizzles as bit permutations; col8 and col4 also XOR in row bits
  function automatic logic [4:0] blk32(input logic [1:0] r, input logic [2:0] c);
    return {c[2], r[1], c[1], r[0], c[0]};
  endfunction
  function automatic logic [4:0] blk16(input logic [2:0] r, input logic [1:0] c);
    return {r[2], c[1], r[1], c[0], r[0]};
  endfunction
  function automatic logic [4:0] blk16s(input logic [2:0] r, input logic [1:0] c);
    return {c[1], r[1], r[2], c[0], r[0]};
  endfunction
  function automatic logic [5:0] col32(input logic [2:0] r, input logic [2:0] c);
    return {r[2:1], c[2:1], r[0], c[0]};
  endfunction
  function automatic logic [6:0] col16(input logic [2:0] r, input logic [3:0] c);
    return {r[2:1], c[2:1], r[0], c[0], c[3]};
  endfunction
  function automatic logic [7:0] col8(input logic [3:0] r, input logic [3:0] c);
    return {r[3], r[2], c[2] ^ r[1] ^ r[2], c[1], r[0], c[0], c[3], r[1]};
  endfunction
  function automatic logic [8:0] col4(input logic [3:0] r, input logic [4:0] c);
    return {r[3], r[2], c[2] ^ r[1] ^ r[2], c[1], r[0], c[0], c[4], c[3], r[1]};
  endfunction
  function automatic logic [7:0] pal32(input logic [7:0] i);
    return {i[7], i[4], i[6], i[5], i[2], i[1], i[3], i[0]};
  endfunction
  function automatic logic [7:0] pal16(input logic [7:0] i);
    return {i[7], i[6], i[5], i[2], i[1], i[3], i[0], i[4]};
  endfunction

  logic        eight;
  logic [7:0]  idx;
  logic [5:0]  ppsm;
  logic [10:0] px, py;
  logic [13:0] pbp;
  logic [5:0]  pbw;
  swz_t        sw;
  kind_t       pkind;
  logic        pok, pz, hib, nfix_en, nfix;
  logic [5:0]  ry, pw;
  logic [4:0]  cx, blk;
  logic [7:0]  off;
  logic        snib;
  logic [8:0]  c4;
  logic [11:0] prod;
  logic [12:0] page;
  logic [26:0] psum;
  logic [AW-1:0]  pbyte;
  logic [WAW-1:0] pword;
  logic [1:0]  plane;
  logic        pnib;
  logic [23:0] l32, l16;
  logic [22:0] b32, b16;
  logic        cfok;

  // Select pixel coordinates: request or palette row
  always_comb begin
    eight = (req.psm == PSM_T8) || (req.psm == PSM_T8H);
    idx   = eight ? req.value[7:0] : {4'd0, req.value[3:0]};
    if (req.op == OP_PAL) begin
      ppsm = {2'b00, cfg.clut_format};
      px   = {1'b0, cfg.clut_origin[5:0], 4'd0} + {3'd0, idx};
      py   = {1'b0, cfg.clut_origin[15:6]};
      pbp  = cfg.clut_base;
      pbw  = cfg.clut_width;
    end else begin
      ppsm = req.psm;
      px   = req.x;
      py   = req.y;
      pbp  = req.bp;
      pbw  = req.bw;
    end
  end

  // Decode the storage format
  always_comb begin
    sw      = SW_32;
    pkind   = K_NONE;
    pok     = 1'b1;
    pz      = 1'b0;
    hib     = 1'b0;
    nfix_en = 1'b0;
    nfix    = 1'b0;
    case (ppsm)
      PSM_C32, PSM_Z32: begin
        pkind = K_W32;
        pz    = (ppsm == PSM_Z32);
      end
      PSM_C24, PSM_Z24: begin
        pkind = K_W24;
        pz    = (ppsm == PSM_Z24);
      end
      PSM_C16, PSM_Z16: begin
        sw    = SW_16;
        pkind = K_H16;
        pz    = (ppsm == PSM_Z16);
      end
      PSM_C16S, PSM_Z16S: begin
        sw    = SW_16S;
        pkind = K_H16;
        pz    = (ppsm == PSM_Z16S);
      end
      PSM_T8: begin
        sw    = SW_8;
        pkind = K_B8;
      end
      PSM_T4: begin
        sw    = SW_4;
        pkind = K_N4;
      end
      PSM_T8H: begin
        pkind = K_B8;
        hib   = 1'b1;
      end
      PSM_T4HL, PSM_T4HH: begin
        pkind   = K_N4;
        hib     = 1'b1;
        nfix_en = 1'b1;
        nfix    = (ppsm == PSM_T4HH);
      end
      default: pok = 1'b0;
    endcase
  end

  // Page grid and in-page swizzle
  always_comb begin
    c4 = col4(py[3:0], px[4:0]);
    snib = 1'b0;
    case (sw)
      SW_32: begin
        ry  = py[10:5];
        cx  = px[10:6];
        pw  = pbw;
        blk = blk32(py[4:3], px[5:3]);
        off = {col32(py[2:0], px[2:0]), 2'b00};
      end
      SW_16, SW_16S: begin
        ry  = {1'b0, py[10:6]};
        cx  = px[10:6];
        pw  = pbw;
        blk = (sw == SW_16S) ? blk16s(py[5:3], px[5:4]) : blk16(py[5:3], px[5:4]);
        off = {col16(py[2:0], px[3:0]), 1'b0};
      end
      SW_8: begin
        ry  = {1'b0, py[10:6]};
        cx  = {1'b0, px[10:7]};
        pw  = {1'b0, pbw[5:1]};
        blk = blk32(py[5:4], px[6:4]);
        off = col8(py[3:0], px[3:0]);
      end
      SW_4: begin
        ry   = {2'b00, py[10:7]};
        cx   = {1'b0, px[10:7]};
        pw   = {1'b0, pbw[5:1]};
        blk  = blk16(py[6:4], px[6:5]);
        off  = c4[8:1];
        snib = c4[0];
      end
      default: begin
        ry  = '0;
        cx  = '0;
        pw  = '0;
        blk = '0;
        off = '0;
      end
    endcase
    prod  = {6'd0, ry} * {6'd0, pw};
    page  = {1'b0, prod} + {8'd0, cx};
    psum  = {5'd0, pbp, 8'd0} + {1'b0, page, 13'd0} + {14'd0, blk, off};
    pbyte = psum[AW-1:0];
    pword = pbyte[AW-1:2] ^ (pz ? Z_XOR : '0);
    plane = hib ? 2'd3 : pbyte[1:0];
    pnib  = nfix_en ? nfix : snib;
  end

  // Linear and palette block addresses
  always_comb begin
    l32 = {2'd0, req.bp, 8'd0} + {1'b0, req.lin, 2'b00};
    l16 = {2'd0, req.bp, 8'd0} + {2'd0, req.lin, 1'b0};
    b32 = {1'b0, cfg.clut_base, 8'd0} + {13'd0, pal32(idx), 2'b00};
    b16 = {1'b0, cfg.clut_base, 8'd0} + {14'd0, pal16(idx), 1'b0};
    cfok = (cfg.clut_format == CF_32) || (cfg.clut_format == CF_24) ||
           (cfg.clut_format == CF_16) || (cfg.clut_format == CF_16S);
  end

  // Pick the access for the operation
  always_comb begin
    acc.waddr = pword;
    acc.lane  = plane;
    acc.nib   = pnib;
    acc.kind  = K_NONE;
    acc.wr    = 1'b0;
    acc.ok    = 1'b0;
    acc.xp    = XP_NONE;
    acc.zero  = 1'b0;
    case (req.op)
      OP_PIX_WR, OP_PIX_RD: begin
        acc.kind = pkind;
        acc.ok   = pok;
        acc.wr   = (req.op == OP_PIX_WR);
      end
      OP_LIN32_WR, OP_LIN32_RD: begin
        acc.waddr = l32[AW-1:2];
        acc.lane  = 2'd0;
        acc.kind  = K_W32;
        acc.ok    = 1'b1;
        acc.wr    = (req.op == OP_LIN32_WR);
      end
      OP_LIN16_WR, OP_LIN16_RD: begin
        acc.waddr = l16[AW-1:2];
        acc.lane  = l16[1:0];
        acc.kind  = K_H16;
        acc.ok    = 1'b1;
        acc.wr    = (req.op == OP_LIN16_WR);
      end
      OP_PAL: begin
        if (cfok) begin
          acc.ok = 1'b1;
          if (cfg.clut_format == CF_32) begin
            acc.xp = XP_NONE;
          end else if (cfg.clut_format == CF_24) begin
            acc.xp = XP_24;
          end else begin
            acc.xp = XP_16;
          end
          if (cfg.clut_layout_two) begin
            acc.kind = pkind;
            acc.zero = (cfg.clut_width == 6'd0);
          end else if (cfg.clut_format == CF_32 || cfg.clut_format == CF_24) begin
            acc.waddr = b32[AW-1:2];
            acc.lane  = 2'd0;
            acc.kind  = K_W32;
          end else begin
            acc.waddr = b16[AW-1:2];
            acc.lane  = b16[1:0];
            acc.kind  = K_H16;
          end
        end
      end
      default: acc.ok = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/spma_dpath.sv =====
// Data path: extracts the read field, expands palette colours and merges
// write data into the word read back. Depends on spma_pkg.
`default_nettype none
module spma_dpath (
  input  spma_pkg::acc_t    acc,
  input  spma_pkg::cfg_t    cfg,
  input  wire logic [31:0]  rdata,
  input  wire logic [31:0]  value,
  output logic      [31:0]  rd_data,
  output logic      [31:0]  wdata
);
  import spma_pkg::*;

  logic [4:0]  bsh, nsh;
  logic [31:0] raw, exp_d, rgb;
  logic [15:0] c16;
  logic [7:0]  a24, a16;

  assign bsh = {acc.lane, 3'b000};
  assign nsh = {acc.lane, acc.nib, 2'b00};

  // Merge write data into the old word
  always_comb begin
    wdata = rdata;
    case (acc.kind)
      K_W32: wdata = value;
      K_W24: wdata = {rdata[31:24], value[23:0]};
      K_H16: begin
        if (acc.lane[1]) begin
          wdata[31:16] = value[15:0];
        end else begin
          wdata[15:0] = value[15:0];
        end
      end
      K_B8:    wdata[bsh +: 8] = value[7:0];
      K_N4:    wdata[nsh +: 4] = value[3:0];
      default: wdata = rdata;
    endcase
  end

  // Extract the read field
  always_comb begin
    case (acc.kind)
      K_W32:   raw = rdata;
      K_W24:   raw = rdata & RGB24_MASK;
      K_H16:   raw = {16'd0, acc.lane[1] ? rdata[31:16] : rdata[15:0]};
      K_B8:    raw = {24'd0, rdata[bsh +: 8]};
      K_N4:    raw = {28'd0, rdata[nsh +: 4]};
      default: raw = 32'd0;
    endcase
  end

  // Expand palette colours with the alpha registers
  always_comb begin
    rgb = raw & RGB24_MASK;
    c16 = raw[15:0];
    a24 = (cfg.abz && rgb == 32'd0) ? 8'd0 : cfg.alpha0;
    if ((c16 & C16_ATOP) != 16'd0) begin
      a16 = cfg.alpha1;
    end else if (cfg.abz && c16[14:0] == 15'd0) begin
      a16 = 8'd0;
    end else begin
      a16 = cfg.alpha0;
    end
    case (acc.xp)
      XP_24:   exp_d = {a24, rgb[23:0]};
      XP_16:   exp_d = {a16, 5'((c16 & C16_RMASK) >> 10), 3'b000,
                        5'((c16 & C16_GMASK) >> 5), 3'b000, c16[4:0], 3'b000};
      default: exp_d = raw;
    endcase
    rd_data = (acc.wr || acc.zero) ? 32'd0 : exp_d;
  end
endmodule
`default_nettype wire
